// ===== sv/rpa_pkg.sv =====
// shared constants and types of the refcounted page allocator
package rpa_pkg;

  localparam int NumPages  = 32768;
  localparam int PageBytes = 4096;
  localparam int CountW    = 8;

  localparam int PageIdxW  = $clog2(NumPages);
  localparam int DepthW    = $clog2(NumPages + 1);
  localparam int PageShift = $clog2(PageBytes);
  localparam int AddrW     = 28;
  localparam int AllocW    = 27;
  localparam int FreeW     = 28;

  localparam int InW  = 32;
  localparam int OutW = 72;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] CountOne = CountW'(1);

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_ADDREF = 3'd2,
    OP_REPORT = 3'd3,
    OP_FILL   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2,
    ST_OVF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FILL
  } state_t;

endpackage

// ===== sv/refcounted_page_allocator_top.sv =====
// refcounted page allocator: count and free-stack memories with read-modify-write control
//
//  port group  | dir | contents
//  s_t*        | in  | command word: opcode, page_address
//  m_t*        | out | result word: status, allocated_address, count_after, free_space
//  cfg_*       | in  | first_usable_page write
//
// a command: accept issues the memory reads, the execute state then modifies,
// writes back and loads the output register; one command is in flight at a time
// fill: accept, a sweep over every page of the count memory, then execute
// after reset a clearing pass zeroes the count memory, no command taken
// the output register lets the next command in while a result waits; a result
// that cannot be loaded holds the block in its execute cycle
module refcounted_page_allocator_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] opcode, [30:3] page_address, [31] zero
  input  logic [rpa_pkg::InW-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] status, [28:2] allocated_address, [36:29] count_after, [64:37] free_space
  output logic [rpa_pkg::OutW-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [rpa_pkg::PageIdxW-1:0] cfg_data
);
  import rpa_pkg::*;

  // memories
  logic [CountW-1:0]   cnt_mem [NumPages];
  logic [PageIdxW-1:0] stk_mem [NumPages];

  // registers
  state_t              state, state_next;
  logic [2:0]          op;
  logic [PageIdxW-1:0] page;
  logic                bad;
  logic [PageIdxW-1:0] cursor, cursor_next;
  logic [DepthW-1:0]   depth, depth_next;
  logic [PageIdxW-1:0] first;
  logic [CountW-1:0]   cnt_rd;
  logic [PageIdxW-1:0] stk_rd;

  // memory controls
  logic                rd_en;
  logic [PageIdxW-1:0] cnt_raddr, stk_raddr;
  logic                cnt_we, stk_we;
  logic [PageIdxW-1:0] cnt_waddr, stk_waddr, stk_wdata;
  logic [CountW-1:0]   cnt_wdata;

  // result
  logic                out_load;
  status_t             res_status;
  logic [AllocW-1:0]   res_alloc;
  logic [CountW-1:0]   res_cnt;
  logic [FreeW-1:0]    res_free;

  // address decode on the incoming word
  logic [AddrW-1:0]           in_addr;
  logic [AddrW-PageShift-1:0] in_page;
  logic                       in_bad;
  logic [CountW-1:0]          cnt_new;

  assign in_addr = s_tdata[AddrW+2:3];
  assign in_page = in_addr[AddrW-1:PageShift];
  assign in_bad  = (in_addr[PageShift-1:0] != '0)
                || (in_page >= (AddrW-PageShift)'(NumPages))
                || (in_page[PageIdxW-1:0] < first);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_rd <= cnt_mem[cnt_raddr];
      stk_rd <= stk_mem[stk_raddr];
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cursor   <= '0;
      depth    <= '0;
      first    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      depth  <= depth_next;
      if (cfg_valid && cfg_ready) begin
        first <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op   <= s_tdata[2:0];
      page <= in_page[PageIdxW-1:0];
      bad  <= in_bad;
    end
    if (out_load) begin
      m_tdata <= {7'd0, res_free, res_cnt, res_alloc, res_status};
    end
  end

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    depth_next  = depth;
    s_tready    = 1'b0;
    rd_en       = 1'b0;
    cnt_raddr   = in_page[PageIdxW-1:0];
    stk_raddr   = PageIdxW'(depth - DepthW'(1));
    cnt_we      = 1'b0;
    cnt_waddr   = page;
    cnt_wdata   = '0;
    stk_we      = 1'b0;
    stk_waddr   = depth[PageIdxW-1:0];
    stk_wdata   = page;
    out_load    = 1'b0;
    res_status  = ST_OK;
    res_alloc   = '0;
    res_cnt     = '0;
    res_free    = '0;
    cnt_new     = '0;

    unique case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cursor;
        cursor_next = cursor + PageIdxW'(1);
        if (cursor == PageIdxW'(NumPages - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          rd_en = 1'b1;
          if (s_tdata[2:0] == OP_FILL) begin
            state_next  = S_FILL;
            cursor_next = '0;
            depth_next  = '0;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_FILL: begin
        // clear every count, push the usable pages in rising order
        cnt_we    = 1'b1;
        cnt_waddr = cursor;
        if (cursor >= first) begin
          stk_we     = 1'b1;
          stk_wdata  = cursor;
          depth_next = depth + DepthW'(1);
        end
        cursor_next = cursor + PageIdxW'(1);
        if (cursor == PageIdxW'(NumPages - 1)) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          unique case (op)
            OP_ALLOC: begin
              if (depth == '0) begin
                res_status = ST_OOM;
              end else begin
                depth_next = depth - DepthW'(1);
                cnt_we     = 1'b1;
                cnt_waddr  = stk_rd;
                cnt_wdata  = CountOne;
                res_alloc  = {stk_rd, {PageShift{1'b0}}};
                res_cnt    = CountOne;
              end
            end
            OP_FREE: begin
              if (bad) begin
                res_status = ST_BAD;
              end else begin
                cnt_new   = (cnt_rd != '0) ? cnt_rd - CountOne : '0;
                cnt_we    = 1'b1;
                cnt_wdata = cnt_new;
                res_cnt   = cnt_new;
                if (cnt_new == '0) begin
                  if (depth == DepthW'(NumPages)) begin
                    res_status = ST_OVF;
                  end else begin
                    stk_we     = 1'b1;
                    depth_next = depth + DepthW'(1);
                  end
                end
              end
            end
            OP_ADDREF: begin
              if (bad) begin
                res_status = ST_BAD;
              end else begin
                cnt_new   = (cnt_rd == CountMax) ? cnt_rd : cnt_rd + CountOne;
                cnt_we    = 1'b1;
                cnt_wdata = cnt_new;
                res_cnt   = cnt_new;
              end
            end
            OP_REPORT: begin
              res_free = FreeW'({depth, {PageShift{1'b0}}});
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // never push past the top of the stack
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> depth < DepthW'(NumPages))
    else $error("push onto full free stack");

  // sweeps only ever write zero counts
  a_sweep_zero: assert property (@(posedge clk) disable iff (rst)
    (cnt_we && (state == S_CLEAR || state == S_FILL)) |-> cnt_wdata == '0)
    else $error("nonzero count written by sweep");

  // fill leaves exactly the usable pages on the stack
  a_fill_depth: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_FILL && state == S_EXEC) |-> depth == DepthW'(NumPages) - DepthW'(first))
    else $error("stack depth wrong after fill");

  // an accepted word always moves on to execute or fill
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC || state == S_FILL))
    else $error("accepted word not processed");

  // a result is loaded only from the execute cycle
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    out_load |-> state == S_EXEC)
    else $error("result loaded outside execute");

endmodule

// ===== dv/tb_refcounted_page_allocator_top.sv =====
// testbench of the refcounted page allocator: directed and random commands against a predictor
`timescale 1ns / 1ps

module tb_refcounted_page_allocator_top;
  import rpa_pkg::*;

  localparam logic [2:0] OpReservedLo = 3'd5;
  localparam logic [2:0] OpReservedHi = 3'd7;
  localparam int MaxPage = NumPages - 1;
  localparam int QuietLimit = 120000;
  localparam int PoolSize = 48;

  typedef struct packed {
    status_t             status;
    logic [AllocW-1:0]   alloc_addr;
    logic [CountW-1:0]   count_after;
    logic [FreeW-1:0]    free_space;
  } alloc_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [InW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OutW-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [PageIdxW-1:0] cfg_data;

  // predictor state
  logic [CountW-1:0]   page_refs [NumPages];
  logic [PageIdxW-1:0] free_stack [NumPages];
  int                  free_depth;
  logic [PageIdxW-1:0] first_page;

  alloc_result_t       expected_q [$];
  logic [PageIdxW-1:0] held_pages [$];
  alloc_result_t       want;
  int                  errors;
  int                  quiet_cycles;
  int                  gap_odds;
  bit                  sink_stalls;

  refcounted_page_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [AddrW-1:0] page_addr(input int pg);
    return AddrW'(pg) << PageShift;
  endfunction

  function automatic alloc_result_t model_command(input logic [2:0] op,
                                                  input logic [AddrW-1:0] addr);
    alloc_result_t r;
    logic [PageIdxW-1:0] pg;
    logic addr_ok;
    r = '0;
    r.status = ST_OK;
    pg = addr[PageShift +: PageIdxW];
    addr_ok = (addr[PageShift-1:0] == '0) && (addr[AddrW-1:PageShift+PageIdxW] == '0)
              && (pg >= first_page);
    case (op)
      OP_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_OOM;
        end else begin
          free_depth--;
          pg = free_stack[free_depth];
          page_refs[pg] = CountOne;
          r.alloc_addr = AllocW'(pg) << PageShift;
          r.count_after = CountOne;
        end
      end
      OP_FREE: begin
        if (!addr_ok) begin
          r.status = ST_BAD;
        end else begin
          if (page_refs[pg] != '0) page_refs[pg]--;
          r.count_after = page_refs[pg];
          if (page_refs[pg] == '0) begin
            if (free_depth >= NumPages) begin
              r.status = ST_OVF;
            end else begin
              free_stack[free_depth] = pg;
              free_depth++;
            end
          end
        end
      end
      OP_ADDREF: begin
        if (!addr_ok) begin
          r.status = ST_BAD;
        end else begin
          if (page_refs[pg] != CountMax) page_refs[pg]++;
          r.count_after = page_refs[pg];
        end
      end
      OP_REPORT: begin
        r.free_space = FreeW'(free_depth) * FreeW'(PageBytes);
      end
      OP_FILL: begin
        free_depth = 0;
        for (int p = 0; p < NumPages; p++) page_refs[p] = '0;
        for (int p = first_page; p < NumPages; p++) begin
          free_stack[free_depth] = PageIdxW'(p);
          free_depth++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // valid stays high between back-to-back words; only a gap or a drain lowers it
  task automatic issue_command(input logic [2:0] op, input logic [AddrW-1:0] addr);
    alloc_result_t r;
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= InW'({addr, op});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = model_command(op, addr);
    expected_q.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) begin
      held_pages.push_back(r.alloc_addr[PageShift +: PageIdxW]);
      if (held_pages.size() > PoolSize) held_pages.delete($urandom_range(0, PoolSize - 1));
    end
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_first_page(input logic [PageIdxW-1:0] page);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= page;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    first_page = page;
  endtask

  task automatic test_empty_allocator();
    issue_command(OP_REPORT, '0);
    issue_command(OP_ALLOC, '1);
    for (int op = OpReservedLo; op <= OpReservedHi; op++) issue_command(3'(op), '1);
    issue_command(OP_FREE, AddrW'(1));
    issue_command(OP_ADDREF, page_addr(NumPages));
    // free of a page never allocated still pushes it
    issue_command(OP_FREE, page_addr(3));
    issue_command(OP_ALLOC, '0);
  endtask

  task automatic test_full_stack();
    write_first_page('0);
    issue_command(OP_FILL, '0);
    issue_command(OP_REPORT, '0);
    issue_command(OP_FREE, page_addr(MaxPage));
    issue_command(OP_ADDREF, '1);
    issue_command(OP_ALLOC, '0);
    issue_command(OP_ADDREF, page_addr(MaxPage));
    issue_command(OP_FREE, page_addr(MaxPage));
    issue_command(OP_FREE, page_addr(MaxPage));
    issue_command(OP_ADDREF, page_addr(0));
  endtask

  task automatic test_first_usable_limit();
    write_first_page(PageIdxW'(MaxPage));
    issue_command(OP_FILL, '1);
    issue_command(OP_REPORT, '0);
    issue_command(OP_FREE, page_addr(MaxPage - 1));
    issue_command(OP_ALLOC, '0);
    issue_command(OP_ALLOC, '0);
    issue_command(OP_ADDREF, page_addr(MaxPage));
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 260; i++) issue_command(OP_ADDREF, page_addr(MaxPage));
    issue_command(OP_FREE, page_addr(MaxPage));
    issue_command(OP_FREE, page_addr(MaxPage));
  endtask

  task automatic run_traffic_phase(input logic [PageIdxW-1:0] first, input bit do_fill,
                                   input int n_items, input bit quiet);
    int kind;
    logic [PageIdxW-1:0] pg;
    logic [AddrW-1:0] a;
    write_first_page(first);
    sink_stalls = !quiet;
    if (do_fill) issue_command(OP_FILL, AddrW'($urandom));
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) gap_odds = quiet ? 0 : $urandom_range(0, 2) * 20;
      // hold off until the block has answered everything
      if (i == n_items / 2) wait_results_drained();
      kind = $urandom_range(0, 99);
      if (held_pages.size() != 0) pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
      else pg = PageIdxW'($urandom_range(0, MaxPage));
      a = AddrW'($urandom);
      if (kind < 32) issue_command(OP_ALLOC, a);
      else if (kind < 57) issue_command(OP_FREE, page_addr(pg));
      else if (kind < 72) issue_command(OP_ADDREF, page_addr(pg));
      else if (kind < 80) issue_command(OP_REPORT, a);
      else if (kind < 94) begin
        if (kind[0]) a = page_addr($urandom_range(0, MaxPage));
        issue_command(kind < 87 ? OP_FREE : OP_ADDREF, a);
      end else issue_command(3'($urandom_range(OpReservedLo, OpReservedHi)), a);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result word with none expected: %h", m_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[28:2] !== want.alloc_addr) begin
          $error("allocated_address: expected %0d, got %0d", want.alloc_addr, m_tdata[28:2]);
          errors++;
        end
        if (m_tdata[36:29] !== want.count_after) begin
          $error("count_after: expected %0d, got %0d", want.count_after, m_tdata[36:29]);
          errors++;
        end
        if (m_tdata[64:37] !== want.free_space) begin
          $error("free_space: expected %0d, got %0d", want.free_space, m_tdata[64:37]);
          errors++;
        end
      end
    end
  end

  // covers the clearing pass and a fill with room to spare
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("refcounted_page_allocator_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall_odds;
    stall_odds = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) stall_odds = $urandom_range(0, 3) * 10;
      if (sink_stalls && stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    errors = 0;
    quiet_cycles = 0;
    gap_odds = 25;
    sink_stalls = 1'b1;
    free_depth = 0;
    first_page = '0;
    for (int p = 0; p < NumPages; p++) page_refs[p] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_allocator();
    test_full_stack();
    test_first_usable_limit();
    test_count_saturation();
    run_traffic_phase('0, 1'b1, 300, 1'b0);
    run_traffic_phase(PageIdxW'($urandom_range(1, MaxPage - 1)), 1'b1, 250, 1'b0);
    run_traffic_phase(PageIdxW'(MaxPage), 1'b1, 150, 1'b0);
    run_traffic_phase(PageIdxW'($urandom_range(NumPages / 2, MaxPage - 8)), 1'b0, 250, 1'b0);
    run_traffic_phase('0, 1'b1, 300, 1'b1);

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("results never returned: %0d", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("refcounted_page_allocator_top: match");
    end else begin
      $display("refcounted_page_allocator_top: mismatch");
    end
    $finish;
  end

endmodule
